// File: rtl/core/pdcu_pkg.sv
// shared types and constants for the periodic deadline catch-up block
package pdcu_pkg;

    localparam int TIME_W = 64;
    localparam int IVL_W  = 32;
    localparam int CNT_W  = $clog2(TIME_W);

    localparam logic [IVL_W-1:0] IVL_RESET = 32'd10000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD,
        ST_DIVS,
        ST_DIV,
        ST_FIX,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic en;
        logic first;
        logic cin0;
        logic inv_b;
    } t_cell_ctl;

endpackage

// File: rtl/core/pdcu_bit_adder.sv
// bit-serial adder and subtractor cell, lsb first, with carry flop
module pdcu_bit_adder (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pdcu_pkg::t_cell_ctl i_ctl,
    input  logic                i_a,
    input  logic                i_b,
    output logic                o_sum,
    output logic                o_carry
);
    import pdcu_pkg::*;

    logic r_c;
    logic w_c;
    logic w_b;

    assign w_c     = i_ctl.first ? i_ctl.cin0 : r_c;
    assign w_b     = i_b ^ i_ctl.inv_b;
    assign o_sum   = i_a ^ w_b ^ w_c;
    assign o_carry = (i_a & w_b) | (i_a & w_c) | (w_b & w_c);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c <= 1'b0;
        end else if (i_ctl.en) begin
            r_c <= o_carry;
        end
    end

endmodule

// File: rtl/core/pdcu_divider.sv
// restoring divider, one quotient bit per cycle
module pdcu_divider (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [pdcu_pkg::TIME_W-1:0]  i_dividend,
    input  logic [pdcu_pkg::IVL_W-1:0]   i_divisor,
    output logic                         o_done,
    output logic [pdcu_pkg::TIME_W-1:0]  o_quot,
    output logic [pdcu_pkg::IVL_W-1:0]   o_rem
);
    import pdcu_pkg::*;

    logic [TIME_W-1:0] r_q;
    logic [IVL_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [IVL_W:0]    w_trial;
    logic [IVL_W:0]    w_diff;
    logic              w_ge;

    assign w_trial = {r_rem, r_q[TIME_W-1]};
    assign w_ge    = w_trial >= {1'b0, i_divisor};
    assign w_diff  = w_trial - {1'b0, i_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(TIME_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_q   <= {r_q[TIME_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[IVL_W-1:0] : w_trial[IVL_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_rem;

    a_rem_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_rem < i_divisor))
        else $error("remainder not below divisor");

endmodule

// File: rtl/core/periodic_deadline_catch_up_top.sv
// top level of the periodic deadline catch-up block
//
// One request on the input channel (i_valid / o_ready, field i_time_now) is one
// timer acknowledge. The block returns one result on the output channel
// (o_valid / i_ready) with the new compare value and the number of extra
// whole intervals skipped, and keeps that compare value as its deadline.
// The interval is written through i_cfg_we / i_cfg_data; the user must write
// it only while idle, as the block does not enforce this. Zero acts as one.
// Arithmetic is bit-serial: one serial pass forms deadline plus interval,
// time minus that, and time plus interval. A request that needs no catch-up
// then has its result loaded into the output register; a catch-up request
// first runs the restoring divider and a second serial pass that forms time
// plus interval minus remainder, and the quotient plus one.
// One request is in flight at a time; o_ready is high only while idle. The
// result sits in an output register, so a new request is taken while the
// previous result waits for i_ready; a finished request waits until that
// register is free.
// Reset (synchronous, active low) disarms the deadline, sets the interval
// to 10000 and drops any result in flight.
module periodic_deadline_catch_up_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [pdcu_pkg::IVL_W-1:0]   i_cfg_data,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [pdcu_pkg::TIME_W-1:0]  i_time_now,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [pdcu_pkg::TIME_W-1:0]  o_compare_value,
    output logic [pdcu_pkg::TIME_W-1:0]  o_skipped_intervals
);
    import pdcu_pkg::*;

    t_state            r_state;
    t_state            n_state;
    logic [CNT_W-1:0]  r_cnt;
    logic [IVL_W-1:0]  r_ivl;
    logic [TIME_W-1:0] r_deadline;
    logic              r_armed;
    logic              r_catch;
    logic [TIME_W-1:0] r_a;
    logic [TIME_W-1:0] r_b;
    logic [TIME_W-1:0] r_n;
    logic              r_ov;
    logic [TIME_W-1:0] r_ocmp;
    logic [TIME_W-1:0] r_oskp;

    logic [IVL_W-1:0]  w_ivl_eff;
    logic              w_last;
    logic              w_load_out;
    logic              w_div_start;
    logic              w_div_done;
    logic [TIME_W-1:0] w_quot;
    logic [IVL_W-1:0]  w_rem;
    t_cell_ctl         w_ctl_a;
    t_cell_ctl         w_ctl_b;
    t_cell_ctl         w_ctl_c;
    logic              w_a_in;
    logic              w_b_a_in;
    logic              w_b_b_in;
    logic              w_sum_a;
    logic              w_sum_b;
    logic              w_sum_c;
    logic              w_carry_a;
    logic              w_carry_b;
    logic              w_carry_c;

    assign w_ivl_eff = (r_ivl == '0) ? IVL_W'(1) : r_ivl;
    assign w_last    = r_cnt == CNT_W'(TIME_W - 1);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_valid) n_state = ST_ADD;
            ST_ADD: begin
                if (w_last) n_state = (r_armed && w_carry_b) ? ST_DIVS : ST_DONE;
            end
            ST_DIVS: n_state = ST_DIV;
            ST_DIV:  if (w_div_done) n_state = ST_FIX;
            ST_FIX:  if (w_last) n_state = ST_DONE;
            ST_DONE: if (!r_ov || i_ready) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs and cell control
    always_comb begin
        o_ready     = 1'b0;
        w_div_start = 1'b0;
        w_load_out  = 1'b0;
        w_ctl_a     = '0;
        w_ctl_b     = '0;
        w_ctl_c     = '0;
        w_a_in      = r_a[0];
        w_b_a_in    = r_n[0];
        w_b_b_in    = w_sum_a;
        unique case (r_state)
            ST_IDLE: o_ready = 1'b1;
            ST_ADD: begin
                w_ctl_a = '{en: 1'b1, first: r_cnt == '0, cin0: 1'b0, inv_b: 1'b0};
                w_ctl_b = '{en: 1'b1, first: r_cnt == '0, cin0: 1'b1, inv_b: 1'b1};
                w_ctl_c = '{en: 1'b1, first: r_cnt == '0, cin0: 1'b0, inv_b: 1'b0};
            end
            ST_DIVS: w_div_start = 1'b1;
            ST_DIV: begin
            end
            ST_FIX: begin
                w_ctl_a  = '{en: 1'b1, first: r_cnt == '0, cin0: 1'b1, inv_b: 1'b1};
                w_ctl_b  = '{en: 1'b1, first: r_cnt == '0, cin0: 1'b1, inv_b: 1'b0};
                w_a_in   = r_n[0];
                w_b_a_in = r_a[0];
                w_b_b_in = 1'b0;
            end
            ST_DONE: w_load_out = !r_ov || i_ready;
            default: begin
            end
        endcase
    end

    // deadline plus interval, then time plus interval minus remainder
    pdcu_bit_adder u_cell_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl_a),
        .i_a     (w_a_in),
        .i_b     (r_b[0]),
        .o_sum   (w_sum_a),
        .o_carry (w_carry_a)
    );

    // time minus new deadline, then quotient plus one
    pdcu_bit_adder u_cell_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl_b),
        .i_a     (w_b_a_in),
        .i_b     (w_b_b_in),
        .o_sum   (w_sum_b),
        .o_carry (w_carry_b)
    );

    // time plus interval
    pdcu_bit_adder u_cell_c (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl_c),
        .i_a     (r_n[0]),
        .i_b     (r_b[0]),
        .o_sum   (w_sum_c),
        .o_carry (w_carry_c)
    );

    pdcu_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_b),
        .i_divisor  (w_ivl_eff),
        .o_done     (w_div_done),
        .o_quot     (w_quot),
        .o_rem      (w_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_cnt      <= '0;
            r_ivl      <= IVL_RESET;
            r_deadline <= '0;
            r_armed    <= 1'b0;
            r_catch    <= 1'b0;
            r_ov       <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_ivl <= i_cfg_data;
            if (r_state == ST_ADD || r_state == ST_FIX) r_cnt <= r_cnt + 1'b1;
            if (r_state == ST_IDLE && i_valid) r_armed <= r_deadline != '0;
            if (r_state == ST_ADD && w_last) r_catch <= r_armed && w_carry_b;
            if (w_load_out) begin
                r_deadline <= r_catch ? r_n : r_a;
                r_ov       <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // shift registers and output payload
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    r_a <= (r_deadline == '0) ? i_time_now : r_deadline;
                    r_b <= {{(TIME_W - IVL_W){1'b0}}, w_ivl_eff};
                    r_n <= i_time_now;
                end
            end
            ST_ADD: begin
                r_a <= {w_sum_a, r_a[TIME_W-1:1]};
                r_b <= {w_sum_b, r_b[TIME_W-1:1]};
                r_n <= {w_sum_c, r_n[TIME_W-1:1]};
            end
            ST_DIV: begin
                if (w_div_done) begin
                    r_a <= w_quot;
                    r_b <= {{(TIME_W - IVL_W){1'b0}}, w_rem};
                end
            end
            ST_FIX: begin
                r_a <= {w_sum_b, r_a[TIME_W-1:1]};
                r_b <= {1'b0, r_b[TIME_W-1:1]};
                r_n <= {w_sum_a, r_n[TIME_W-1:1]};
            end
            default: begin
            end
        endcase
        if (w_load_out) begin
            r_ocmp <= r_catch ? r_n : r_a;
            r_oskp <= r_catch ? r_a : '0;
        end
    end

    assign o_valid             = r_ov;
    assign o_compare_value     = r_ocmp;
    assign o_skipped_intervals = r_oskp;

    a_deadline_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load_out |=> (r_deadline == o_compare_value) && o_valid)
        else $error("stored deadline differs from result");

    a_div_only_late: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_catch && r_armed))
        else $error("divider running without catch-up");

    a_pass_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ADD && !w_last) |=> (r_state == ST_ADD))
        else $error("serial pass ended early");

endmodule
